// File: hw/rtl/u3g_pkg.sv
// Shared types and constants for the U3 gate matrix generator.
// Used by u3g_sincos and u3_gate_matrix_gen_top; depends on nothing.
package u3g_pkg;

  // Default field geometry
  localparam int ANGLE_BITS_DEF      = 16;
  localparam int VALUE_FRAC_BITS_DEF = 14;

  // Internal trig precision: Q30
  localparam logic [30:0] Q_ONE     = 31'h4000_0000;
  localparam logic [32:0] PI_SCALED = 33'd6746518852;

  // Sine/cosine pipeline depth in stages
  localparam int SC_LAT = 18;

  // Horner step divisors and their ceil(log2) shifts; the last sine step is the z*t multiply
  localparam int SIN_K [7] = '{156, 110, 72, 42, 20, 6, 1};
  localparam int SIN_L [7] = '{8, 7, 7, 6, 5, 3, 0};
  localparam int COS_K [7] = '{182, 132, 90, 56, 30, 12, 2};
  localparam int COS_L [7] = '{8, 8, 7, 6, 5, 4, 1};

  typedef enum logic [1:0] {
    OP_MATRIX   = 2'd0,
    OP_D_THETA  = 2'd1,
    OP_D_PHI    = 2'd2,
    OP_D_LAMBDA = 2'd3
  } op_t;

  // Sideband carried along the sine/cosine pipeline
  typedef struct packed {
    logic [1:0]  quad;
    logic        hi;
    logic [29:0] z;
    logic [29:0] z2;
  } sc_side_t;

endpackage

// File: hw/rtl/u3g_sincos.sv
// Pipelined Q30 cosine and sine of a 32-bit phase (octant fold, Horner series).
// Depends on u3g_pkg; stage enables come from the top-level stall chain.
module u3g_sincos (
  input  logic                        clk,
  input  logic [u3g_pkg::SC_LAT-1:0]  en,
  input  logic [31:0]                 phase,
  output logic signed [31:0]          cos_o,
  output logic signed [31:0]          sin_o
);
  import u3g_pkg::*;

  logic [29:0]  r0_r;
  logic [1:0]   quad0_r;
  logic         hi0_r;
  logic [29:0]  z1_r;
  logic [1:0]   quad1_r;
  logic         hi1_r;
  logic [62:0]  zprod;
  logic [59:0]  zsq;
  sc_side_t     sd2_r;
  logic [29:0]  ps_r [7];
  logic [29:0]  pc_r [7];
  logic [30:0]  ts_r [7];
  logic [30:0]  tc_r [7];
  sc_side_t     sdm_r [7];
  sc_side_t     sdd_r [7];
  logic [30:0]  sa, ca;
  logic signed [31:0] cs, sn;
  logic signed [31:0] cos_r, sin_r;

  // Fold phase into the first octant
  always_ff @(posedge clk) begin
    if (en[0]) begin
      quad0_r <= phase[31:30];
      hi0_r   <= phase[29];
      r0_r    <= phase[29] ? 30'(30'h2000_0000 - {1'b0, phase[28:0]}) : {1'b0, phase[28:0]};
    end
  end

  // Scale offset to radians in Q30
  assign zprod = 63'(r0_r) * 63'(PI_SCALED);
  always_ff @(posedge clk) begin
    if (en[1]) begin
      z1_r    <= zprod[61:32];
      quad1_r <= quad0_r;
      hi1_r   <= hi0_r;
    end
  end

  // Square of z
  assign zsq = 60'(z1_r) * 60'(z1_r);
  always_ff @(posedge clk) begin
    if (en[2]) begin
      sd2_r.quad <= quad1_r;
      sd2_r.hi   <= hi1_r;
      sd2_r.z    <= z1_r;
      sd2_r.z2   <= zsq[59:30];
    end
  end

  // Horner steps: one multiply stage, then one reciprocal-divide stage
  for (genvar j = 0; j < 7; j++) begin : g_step
    localparam logic [31:0] MS = 32'(((64'd1 << (30 + SIN_L[j])) + 64'(SIN_K[j]) - 64'd1)
                                     / 64'(SIN_K[j]));
    localparam logic [31:0] MC = 32'(((64'd1 << (30 + COS_L[j])) + 64'(COS_K[j]) - 64'd1)
                                     / 64'(COS_K[j]));
    logic [30:0] tin_s, tin_c;
    logic [29:0] ain_s;
    sc_side_t    side_in;
    logic [60:0] mul_s, mul_c;
    logic [61:0] dq_s, dq_c;
    logic [29:0] q_s, q_c;

    if (j == 0) begin : g_first
      assign tin_s   = Q_ONE;
      assign tin_c   = Q_ONE;
      assign side_in = sd2_r;
    end else begin : g_next
      assign tin_s   = ts_r[j-1];
      assign tin_c   = tc_r[j-1];
      assign side_in = sdd_r[j-1];
    end

    // Last sine slot forms z*t instead of z2*t
    assign ain_s = (j == 6) ? side_in.z : side_in.z2;
    assign mul_s = 61'(ain_s) * 61'(tin_s);
    assign mul_c = 61'(side_in.z2) * 61'(tin_c);

    always_ff @(posedge clk) begin
      if (en[3 + 2*j]) begin
        ps_r[j]  <= mul_s[59:30];
        pc_r[j]  <= mul_c[59:30];
        sdm_r[j] <= side_in;
      end
    end

    // Exact truncating divide by constant via reciprocal
    assign dq_s = 62'(ps_r[j]) * 62'(MS);
    assign dq_c = 62'(pc_r[j]) * 62'(MC);
    assign q_s  = 30'(dq_s >> (30 + SIN_L[j]));
    assign q_c  = 30'(dq_c >> (30 + COS_L[j]));

    always_ff @(posedge clk) begin
      if (en[4 + 2*j]) begin
        ts_r[j]  <= (j == 6) ? {1'b0, ps_r[j]} : 31'(Q_ONE - {1'b0, q_s});
        tc_r[j]  <= 31'(Q_ONE - {1'b0, q_c});
        sdd_r[j] <= sdm_r[j];
      end
    end
  end

  // Undo octant and quadrant folding
  always_comb begin
    sa = sdd_r[6].hi ? tc_r[6] : ts_r[6];
    ca = sdd_r[6].hi ? ts_r[6] : tc_r[6];
    cs = $signed({1'b0, ca});
    sn = $signed({1'b0, sa});
  end

  always_ff @(posedge clk) begin
    if (en[SC_LAT-1]) begin
      case (sdd_r[6].quad)
        2'd0: begin
          cos_r <= cs;
          sin_r <= sn;
        end
        2'd1: begin
          cos_r <= -sn;
          sin_r <= cs;
        end
        2'd2: begin
          cos_r <= -cs;
          sin_r <= -sn;
        end
        default: begin
          cos_r <= sn;
          sin_r <= -cs;
        end
      endcase
    end
  end

  assign cos_o = cos_r;
  assign sin_o = sin_r;

endmodule

// File: hw/rtl/u3_gate_matrix_gen_top.sv
// U3 gate unitary and derivative generator, top level.
// Each word passes the phase register, the sine/cosine pipelines, then the product, sign and rounding registers.
// Throughput: one word per cycle while the output is not stalled; four sine/cosine pipelines run in parallel.
// A stalled output holds the pipeline from the back; bubbles still fill.
// Reset (rst_n low, synchronous) clears all stage valid bits; data is not reset.
// Depends on u3g_pkg and u3g_sincos.
module u3_gate_matrix_gen_top #(
  parameter  int ANGLE_BITS      = u3g_pkg::ANGLE_BITS_DEF,
  parameter  int VALUE_FRAC_BITS = u3g_pkg::VALUE_FRAC_BITS_DEF,
  localparam int IN_W            = ((2 + 3*ANGLE_BITS + 7) / 8) * 8,
  localparam int OUT_W           = 8 * (VALUE_FRAC_BITS + 2)
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_tvalid,
  output logic             in_tready,
  // operation, theta_angle, phi_angle, lambda_angle, zero pad
  input  logic [IN_W-1:0]  in_tdata,
  output logic             out_tvalid,
  input  logic             out_tready,
  // m00_re, m00_im, m01_re, m01_im, m10_re, m10_im, m11_re, m11_im
  output logic [OUT_W-1:0] out_tdata
);
  import u3g_pkg::*;

  localparam int AB  = ANGLE_BITS;
  localparam int OW  = VALUE_FRAC_BITS + 2;
  localparam int NST = SC_LAT + 4;
  localparam int SH0 = 60 - VALUE_FRAC_BITS;
  localparam logic [61:0] HALF0 = 62'd1 << (SH0 - 1);
  localparam logic [61:0] HALF1 = 62'd1 << SH0;
  localparam logic [7:0]  NEG_MASK = 8'b0000_1100;

  logic [NST-1:0] vld_r;
  logic [NST-1:0] en;
  op_t            op_r [NST-1];

  op_t            in_op;
  logic [AB-1:0]  in_th, in_ph, in_la;
  logic [AB:0]    th_x;
  logic [AB-1:0]  ph_x, la_x, eq_x;
  logic [31:0]    phase_r [4];

  logic signed [31:0] cosv [4];
  logic signed [31:0] sinv [4];
  logic signed [61:0] prod_nxt [8];
  logic signed [61:0] prod_r [8];
  logic [60:0]        abs_r [8];
  logic [7:0]         sgn_r;
  logic [OW-1:0]      res_r [8];

  // Stall chain from the output back
  always_comb begin
    en[NST-1] = !vld_r[NST-1] || out_tready;
    for (int i = NST - 2; i >= 0; i--) begin
      en[i] = !vld_r[i] || en[i+1];
    end
  end

  assign in_tready  = en[0];
  assign out_tvalid = vld_r[NST-1];

  // Advance valid bits and carry the operation
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      if (en[0]) vld_r[0] <= in_tvalid;
      for (int i = 1; i < NST; i++) begin
        if (en[i]) vld_r[i] <= vld_r[i-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en[0]) op_r[0] <= in_op;
    for (int i = 1; i < NST - 1; i++) begin
      if (en[i]) op_r[i] <= op_r[i-1];
    end
  end

  // Unpack word and form offset phases
  always_comb begin
    in_op = op_t'(in_tdata[1:0]);
    in_th = in_tdata[2 +: AB];
    in_ph = in_tdata[2 + AB +: AB];
    in_la = in_tdata[2 + 2*AB +: AB];
    th_x  = {in_th[AB-1], in_th} + ((in_op == OP_D_THETA) ? ((AB+1)'(1) << (AB - 1)) : '0);
    ph_x  = in_ph + ((in_op == OP_D_PHI) ? (AB'(1) << (AB - 2)) : '0);
    la_x  = in_la + ((in_op == OP_D_LAMBDA) ? (AB'(1) << (AB - 2)) : '0);
    eq_x  = ph_x + la_x;
  end

  always_ff @(posedge clk) begin
    if (en[0]) begin
      phase_r[0] <= {th_x, {(31 - AB){1'b0}}};
      phase_r[1] <= {ph_x, {(32 - AB){1'b0}}};
      phase_r[2] <= {la_x, {(32 - AB){1'b0}}};
      phase_r[3] <= {eq_x, {(32 - AB){1'b0}}};
    end
  end

  // Half theta, phi, lambda, phi plus lambda
  for (genvar g = 0; g < 4; g++) begin : g_trig
    u3g_sincos u_sincos (
      .clk   (clk),
      .en    (en[SC_LAT:1]),
      .phase (phase_r[g]),
      .cos_o (cosv[g]),
      .sin_o (sinv[g])
    );
  end

  // Form Q60 products
  always_comb begin
    prod_nxt[0] = $signed({cosv[0], 30'd0});
    prod_nxt[1] = '0;
    prod_nxt[2] = 62'(64'(cosv[2]) * 64'(sinv[0]));
    prod_nxt[3] = 62'(64'(sinv[2]) * 64'(sinv[0]));
    prod_nxt[4] = 62'(64'(cosv[1]) * 64'(sinv[0]));
    prod_nxt[5] = 62'(64'(sinv[1]) * 64'(sinv[0]));
    prod_nxt[6] = 62'(64'(cosv[3]) * 64'(cosv[0]));
    prod_nxt[7] = 62'(64'(sinv[3]) * 64'(cosv[0]));
  end

  always_ff @(posedge clk) begin
    if (en[SC_LAT+1]) begin
      for (int k = 0; k < 8; k++) prod_r[k] <= prod_nxt[k];
    end
  end

  // Split into sign and magnitude, folding in the negated entries
  always_ff @(posedge clk) begin
    if (en[SC_LAT+2]) begin
      for (int k = 0; k < 8; k++) begin
        sgn_r[k] <= prod_r[k][61] ^ NEG_MASK[k];
        abs_r[k] <= prod_r[k][61] ? 61'(-prod_r[k]) : 61'(prod_r[k]);
      end
    end
  end

  // Round to nearest, ties away from zero, and zero the unused entries
  always_ff @(posedge clk) begin
    if (en[NST-1]) begin
      for (int k = 0; k < 8; k++) begin
        logic [61:0]   sum;
        logic [OW-1:0] mag;
        logic          zero;
        sum  = (op_r[NST-2] == OP_D_THETA) ? ({1'b0, abs_r[k]} + HALF1)
                                            : ({1'b0, abs_r[k]} + HALF0);
        mag  = (op_r[NST-2] == OP_D_THETA) ? OW'(sum >> (SH0 + 1)) : OW'(sum >> SH0);
        case (op_r[NST-2])
          OP_D_PHI:    zero = (k < 4);
          OP_D_LAMBDA: zero = (k < 2) || (k == 4) || (k == 5);
          default:     zero = (k == 1);
        endcase
        res_r[k] <= zero ? '0 : (sgn_r[k] ? OW'(-mag) : mag);
      end
    end
  end

  for (genvar g = 0; g < 8; g++) begin : g_pack
    assign out_tdata[g*OW +: OW] = res_r[g];
  end

endmodule

// File: verif/tb.sv
// Self-checking bench for the U3 gate matrix generator top level.
// Predicts each matrix word in fixed point and compares it field by field;
// depends on u3g_pkg and u3_gate_matrix_gen_top.
module tb;
  import u3g_pkg::*;

  localparam int AB   = ANGLE_BITS_DEF;
  localparam int VF   = VALUE_FRAC_BITS_DEF;
  localparam int OW   = VF + 2;
  localparam int IN_W = ((2 + 3*AB + 7) / 8) * 8;
  localparam int OUT_W = 8 * OW;
  localparam int WATCHDOG = 20000;

  typedef logic signed [OW-1:0] mat_t [8];

  // Q30 sine and cosine on the first octant
  function automatic void octant_sc(input longint unsigned z,
                                    output longint unsigned s,
                                    output longint unsigned c);
    longint unsigned z2, t, one;
    longint unsigned sk [6];
    longint unsigned ck [7];
    sk = '{156, 110, 72, 42, 20, 6};
    ck = '{182, 132, 90, 56, 30, 12, 2};
    one = 64'd1 << 30;
    z2 = (z * z) >> 30;
    t = one;
    for (int i = 0; i < 6; i++) t = one - ((z2 * t) >> 30) / sk[i];
    s = (z * t) >> 30;
    t = one;
    for (int i = 0; i < 7; i++) t = one - ((z2 * t) >> 30) / ck[i];
    c = t;
  endfunction

  // Signed Q30 cosine and sine of a 32-bit phase
  function automatic void phase_cs(input logic [31:0] ph,
                                   output longint cv, output longint sv);
    logic [1:0] quad;
    logic [29:0] inq;
    longint unsigned r, so, co, sa, ca;
    quad = ph[31:30];
    inq = ph[29:0];
    r = inq[28:0];
    if (inq[29]) begin
      r = 64'h2000_0000 - r;
      octant_sc((r * 64'd6746518852) >> 32, so, co);
      sa = co; ca = so;
    end else begin
      octant_sc((r * 64'd6746518852) >> 32, so, co);
      sa = so; ca = co;
    end
    case (quad)
      2'd0: begin cv = ca; sv = sa; end
      2'd1: begin cv = -longint'(sa); sv = ca; end
      2'd2: begin cv = -longint'(ca); sv = -longint'(sa); end
      default: begin cv = sa; sv = -longint'(ca); end
    endcase
  endfunction

  function automatic logic signed [OW-1:0] round_q(longint v, int extra);
    int sh;
    longint unsigned mag;
    longint res;
    sh = 60 - VF + extra;
    if (v < 0) begin
      mag = (longint'(-v) + (64'd1 << (sh - 1))) >> sh;
      res = -longint'(mag);
    end else begin
      mag = (longint'(v) + (64'd1 << (sh - 1))) >> sh;
      res = mag;
    end
    return res[OW-1:0];
  endfunction

  // Expected matrix for one angle word
  function automatic mat_t u3_matrix(op_t op, logic signed [AB-1:0] th_a,
                                     logic signed [AB-1:0] ph_a,
                                     logic signed [AB-1:0] la_a);
    longint th, ph, la, c, s, pc, ps, lc, ls, qc, qs;
    logic [63:0] w;
    int extra;
    mat_t m;
    th = th_a; ph = ph_a; la = la_a; extra = 0;
    case (op)
      OP_D_THETA:  begin th += 64'sd1 <<< (AB - 1); extra = 1; end
      OP_D_PHI:    ph += 64'sd1 <<< (AB - 2);
      OP_D_LAMBDA: la += 64'sd1 <<< (AB - 2);
      default: ;
    endcase
    w = th << (31 - AB); phase_cs(w[31:0], c, s);
    w = ph << (32 - AB); phase_cs(w[31:0], pc, ps);
    w = la << (32 - AB); phase_cs(w[31:0], lc, ls);
    w = (ph + la) << (32 - AB); phase_cs(w[31:0], qc, qs);
    m[0] = round_q(c * (64'sd1 << 30), extra);
    m[1] = '0;
    m[2] = round_q(-(lc * s), extra);
    m[3] = round_q(-(ls * s), extra);
    m[4] = round_q(pc * s, extra);
    m[5] = round_q(ps * s, extra);
    m[6] = round_q(qc * c, extra);
    m[7] = round_q(qs * c, extra);
    if (op == OP_D_PHI) begin
      m[0] = '0; m[1] = '0; m[2] = '0; m[3] = '0;
    end else if (op == OP_D_LAMBDA) begin
      m[0] = '0; m[1] = '0; m[4] = '0; m[5] = '0;
    end
    return m;
  endfunction

  // Queue of expected matrices, checked in order
  class matrix_board;
    logic [OUT_W-1:0] pending [$];
    int errors = 0;
    string names [8] = '{"m00_re", "m00_im", "m01_re", "m01_im",
                         "m10_re", "m10_im", "m11_re", "m11_im"};

    function void note_angles(logic [IN_W-1:0] d);
      mat_t m;
      logic [OUT_W-1:0] p;
      m = u3_matrix(op_t'(d[1:0]), d[2 +: AB], d[2+AB +: AB], d[2+2*AB +: AB]);
      for (int i = 0; i < 8; i++) p[i*OW +: OW] = m[i];
      pending.push_back(p);
    endfunction

    function void check_matrix(logic [OUT_W-1:0] got);
      logic [OUT_W-1:0] exp_w;
      if (pending.size() == 0) begin
        $error("unexpected result word %h", got);
        errors++;
        return;
      end
      exp_w = pending.pop_front();
      for (int i = 0; i < 8; i++)
        if (got[i*OW +: OW] !== exp_w[i*OW +: OW]) begin
          $error("%s expected %0d actual %0d", names[i],
                 $signed(exp_w[i*OW +: OW]), $signed(got[i*OW +: OW]));
          errors++;
        end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_tvalid = 1'b0;
  logic in_tready;
  logic [IN_W-1:0] in_tdata = '0;
  logic out_tvalid;
  logic out_tready = 1'b0;
  logic [OUT_W-1:0] out_tdata;

  int send_idle = 0;
  int recv_idle = 0;
  int hold_cycles = 0;
  int quiet = 0;
  matrix_board board = new();

  always #4 clk = ~clk;

  u3_gate_matrix_gen_top dut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata)
  );

  // Check results and drive receiver readiness
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) board.check_matrix(out_tdata);
    if (hold_cycles > 0) begin
      hold_cycles <= hold_cycles - 1;
      out_tready <= 1'b0;
    end else begin
      out_tready <= rst_n && ($urandom_range(99) >= recv_idle);
    end
  end

  // Count cycles with no word moving
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      quiet <= 0;
    end else if (quiet >= WATCHDOG) begin
      $display("tb: FAIL");
      $finish;
    end else begin
      quiet <= quiet + 1;
    end
  end

  // Offer one angle word and wait for it to be taken; idle cycles drop valid
  task automatic send_angles(op_t op, logic [AB-1:0] th, logic [AB-1:0] ph,
                             logic [AB-1:0] la);
    logic [IN_W-1:0] d;
    while ($urandom_range(99) < send_idle) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    d = '0;
    d[1:0] = op;
    d[2 +: AB] = th;
    d[2+AB +: AB] = ph;
    d[2+2*AB +: AB] = la;
    in_tvalid <= 1'b1;
    in_tdata <= d;
    do @(posedge clk); while (!in_tready);
    board.note_angles(d);
  endtask

  task automatic send_random(int n);
    logic [AB-1:0] a [3];
    for (int i = 0; i < n; i++) begin
      for (int k = 0; k < 3; k++)
        case ($urandom_range(7))
          0: a[k] = {AB{1'b0}} | (AB'(1) << $urandom_range(AB - 1));
          1: a[k] = AB'($urandom_range(3)) << (AB - 2);
          default: a[k] = AB'($urandom);
        endcase
      send_angles(op_t'($urandom_range(3)), a[0], a[1], a[2]);
    end
  endtask

  // Stop offering and wait for every expected result
  task automatic drain();
    in_tvalid <= 1'b0;
    do @(posedge clk); while (board.pending.size() != 0);
  endtask

  initial begin
    logic [AB-1:0] edges [6];
    edges = '{16'h0000, 16'h7FFF, 16'h8000, 16'hFFFF, 16'h4000, 16'hC000};
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: extreme angles under every operation
    for (int o = 0; o < 4; o++)
      for (int e = 0; e < 6; e++)
        send_angles(op_t'(o), edges[e], edges[(e + o) % 6], edges[(e + 3) % 6]);
    drain();

    // Stall the receiver while the sender keeps offering
    hold_cycles <= 200;
    send_random(60);
    drain();

    send_idle = 36; recv_idle = 73;
    send_random(420);
    send_idle = 73; recv_idle = 36;
    send_random(420);
    send_idle = 0; recv_idle = 0;
    send_random(400);

    drain();
    repeat (30) @(posedge clk);
    if (board.errors == 0 && board.pending.size() == 0) begin
      $display("tb: PASS");
    end else begin
      $display("tb: FAIL");
    end
    $finish;
  end
endmodule

// File: files.f
hw/rtl/u3g_pkg.sv
hw/rtl/u3g_sincos.sv
hw/rtl/u3_gate_matrix_gen_top.sv
verif/tb.sv
